// File: design/mcfe_pkg.sv
// Shared types, frame constants and the CRC-16 byte update for the command frame encoder.
// Depends on nothing; every module of the encoder imports it.
package mcfe_pkg;

	localparam int FrameLen = 9;
	localparam int PosW = 4;
	localparam int FifoDepth = 2;
	localparam int FifoAw = 1;
	localparam int FifoCntW = 2;

	localparam logic [7:0] HDR_SYNC = 8'hFF;
	localparam logic [7:0] HDR_LEN = 8'h07;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// frame byte positions
	localparam logic [PosW-1:0] POS_SYNC = 4'd0;
	localparam logic [PosW-1:0] POS_LEN = 4'd1;
	localparam logic [PosW-1:0] POS_LSPD = 4'd2;
	localparam logic [PosW-1:0] POS_PAD_A = 4'd3;
	localparam logic [PosW-1:0] POS_RSPD = 4'd4;
	localparam logic [PosW-1:0] POS_PAD_B = 4'd5;
	localparam logic [PosW-1:0] POS_FLAGS = 4'd6;
	localparam logic [PosW-1:0] POS_CRC_LO = 4'd7;
	localparam logic [PosW-1:0] POS_CRC_HI = 4'd8;

	typedef struct packed {
		logic [7:0] left_speed;
		logic [7:0] right_speed;
		logic [7:0] flags;
		logic [15:0] crc;
	} frame_cmd_t;

	// one byte of the reflected CRC-16, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// CRC state once the constant length byte has been folded in
	localparam logic [15:0] CRC_AFTER_LEN = crc_byte(CRC_INIT, HDR_LEN);

endpackage

// File: design/motor_command_frame_encoder_top.sv
// Drive command frame encoder, top level: front end, command queue and byte serializer.
// Depends on mcfe_pkg, mcfe_front, mcfe_fifo and mcfe_back.
//
// Input channel: valid/stall with left_speed, right_speed, left_forward, right_forward;
// one word is one drive command. Output channel: valid/stall with frame_byte and
// last_byte; each command produces nine words: 0xFF, 0x07, left speed, 0x00,
// right speed, 0x00, flags, CRC low, CRC high (last_byte set on the CRC high byte).
// The CRC is CRC-16 Modbus over frame bytes 1 to 6.
// Flow: the front end folds one payload byte per cycle into the CRC, then pushes
// the finished command into the queue; its first byte is shown once it is the
// queue head. Throughput: one frame byte per cycle on the output while out_stall
// is low, set by the output serializer. The front end takes a new command only
// once the last one is pushed, and a two-entry queue sits between the two sides,
// so the input keeps accepting while a frame is being sent.
// When out_stall holds, the current byte is held and the queue fills; the input
// then stalls once the queue and front end are occupied. Reset empties the
// queue and returns both sides to the start of a frame; nothing else persists.
module motor_command_frame_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] left_speed,
	input  logic [7:0] right_speed,
	input  logic       left_forward,
	input  logic       right_forward,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       last_byte
);
	import mcfe_pkg::*;

	logic       push;
	logic       full;
	logic       pop;
	logic       not_empty;
	frame_cmd_t push_cmd;
	frame_cmd_t head;

	mcfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (in_valid),
		.stall         (in_stall),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.left_forward  (left_forward),
		.right_forward (right_forward),
		.push          (push),
		.full          (full),
		.push_cmd      (push_cmd)
	);

	mcfe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	mcfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head       (head),
		.pop        (pop),
		.valid      (out_valid),
		.stall      (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

// File: design/mcfe_front.sv
// Front end: takes a drive command, builds the flags byte and folds the payload
// bytes into the CRC one byte per cycle. Uses mcfe_pkg.
module mcfe_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	output logic                    stall,
	input  logic [7:0]              left_speed,
	input  logic [7:0]              right_speed,
	input  logic                    left_forward,
	input  logic                    right_forward,
	output logic                    push,
	input  logic                    full,
	output mcfe_pkg::frame_cmd_t    push_cmd
);
	import mcfe_pkg::*;

	logic                busy_q;
	logic [PosW-1:0]     pos_q;
	logic [15:0]         crc_q;
	logic [7:0]          lspd_q;
	logic [7:0]          rspd_q;
	logic [7:0]          flags_q;
	logic                done;
	logic                accept;
	logic [7:0]          fold_byte;

	assign done   = busy_q && (pos_q == POS_CRC_LO);
	assign push   = done && !full;
	assign stall  = busy_q && !push;
	assign accept = valid && !stall;

	always_comb begin
		unique case (pos_q)
			POS_RSPD:  fold_byte = rspd_q;
			POS_FLAGS: fold_byte = flags_q;
			default:   fold_byte = 8'h00;
		endcase
	end

	assign push_cmd = '{left_speed: lspd_q, right_speed: rspd_q, flags: flags_q, crc: crc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= POS_SYNC;
		end else begin
			priority if (accept) begin
				busy_q <= 1'b1;
				pos_q  <= POS_PAD_A;
			end else if (busy_q && !done) begin
				pos_q <= pos_q + 4'd1;
			end else if (push) begin
				busy_q <= 1'b0;
			end else begin
				// idle, or a finished command waiting on a full queue
				busy_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lspd_q  <= left_speed;
			rspd_q  <= right_speed;
			flags_q <= {1'b0, left_forward, 1'b0, right_forward, 4'h0};
			crc_q   <= crc_byte(CRC_AFTER_LEN, left_speed);
		end else if (busy_q && !done) begin
			crc_q <= crc_byte(crc_q, fold_byte);
		end
	end

endmodule

// File: design/mcfe_fifo.sv
// Two-entry queue of finished commands between the front and back ends.
// Uses mcfe_pkg for the entry type and depth.
module mcfe_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  mcfe_pkg::frame_cmd_t    push_cmd,
	output logic                    full,
	input  logic                    pop,
	output logic                    not_empty,
	output mcfe_pkg::frame_cmd_t    head
);
	import mcfe_pkg::*;

	frame_cmd_t              mem [FifoDepth];
	logic [FifoAw-1:0]       wr_ptr_q;
	logic [FifoAw-1:0]       rd_ptr_q;
	logic [FifoCntW-1:0]     count_q;

	assign full      = (count_q == FifoCntW'(FifoDepth));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/mcfe_back.sv
// Back end: walks the nine frame bytes of the queue head, one word per accepted cycle.
// Uses mcfe_pkg for frame positions and constants.
module mcfe_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    not_empty,
	input  mcfe_pkg::frame_cmd_t    head,
	output logic                    pop,
	output logic                    valid,
	input  logic                    stall,
	output logic [7:0]              frame_byte,
	output logic                    last_byte
);
	import mcfe_pkg::*;

	logic [PosW-1:0] pos_q;
	logic            take;

	assign valid     = not_empty;
	assign take      = not_empty && !stall;
	assign last_byte = (pos_q == POS_CRC_HI);
	assign pop       = take && last_byte;

	always_comb begin
		unique case (pos_q)
			POS_SYNC:   frame_byte = HDR_SYNC;
			POS_LEN:    frame_byte = HDR_LEN;
			POS_LSPD:   frame_byte = head.left_speed;
			POS_RSPD:   frame_byte = head.right_speed;
			POS_FLAGS:  frame_byte = head.flags;
			POS_CRC_LO: frame_byte = head.crc[7:0];
			POS_CRC_HI: frame_byte = head.crc[15:8];
			default:    frame_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_SYNC;
		end else if (take) begin
			// wrap to the header once the CRC high byte goes out
			pos_q <= last_byte ? POS_SYNC : pos_q + 4'd1;
		end
	end

endmodule

// File: sim/tb_motor_command_frame_encoder_top.sv
// Self-checking bench for motor_command_frame_encoder_top: drives drive commands, predicts
// each nine-word frame with its own CRC-16 (reflected 0xA001, seed 0xFFFF) and checks it.
// Depends only on the RTL of the encoder; no files, no arguments.
`timescale 1ns / 1ps

typedef struct packed {
	logic [7:0] data;
	logic       last;
} frame_word_t;

class frame_scoreboard;
	localparam logic [7:0]  SYNC_BYTE = 8'hFF;
	localparam logic [7:0]  LEN_BYTE  = 8'h07;
	localparam logic [15:0] CRC_SEED  = 16'hFFFF;
	localparam logic [15:0] CRC_REFL  = 16'hA001;
	localparam int          WORDS     = 9;

	frame_word_t pending_words[$];
	int          errors = 0;

	// build the frame for one accepted command and queue its words
	function void note_command(logic [7:0] ls, logic [7:0] rs, logic lf, logic rf);
		logic [7:0]  frame [WORDS];
		logic [15:0] crc;
		frame_word_t w;
		frame[0] = SYNC_BYTE;
		frame[1] = LEN_BYTE;
		frame[2] = ls;
		frame[3] = 8'h00;
		frame[4] = rs;
		frame[5] = 8'h00;
		frame[6] = {1'b0, lf, 1'b0, rf, 4'b0000};
		crc = CRC_SEED;
		// CRC covers the length byte through the flags byte
		for (int i = 1; i < 7; i++) begin
			crc = crc ^ {8'h00, frame[i]};
			for (int b = 0; b < 8; b++) begin
				if (crc[0]) begin
					crc = (crc >> 1) ^ CRC_REFL;
				end else begin
					crc = crc >> 1;
				end
			end
		end
		frame[7] = crc[7:0];
		frame[8] = crc[15:8];
		for (int k = 0; k < WORDS; k++) begin
			w.data = frame[k];
			w.last = (k == WORDS - 1);
			pending_words.push_back(w);
		end
	endfunction

	function void check_word(logic [7:0] data, logic last);
		frame_word_t want;
		if (pending_words.size() == 0) begin
			$error("frame_byte: no word expected, got 0x%02h (last_byte %0b)", data, last);
			errors++;
			return;
		end
		want = pending_words.pop_front();
		if (data !== want.data) begin
			$error("frame_byte mismatch: expected 0x%02h, actual 0x%02h", want.data, data);
			errors++;
		end
		if (last !== want.last) begin
			$error("last_byte mismatch: expected %0b, actual %0b", want.last, last);
			errors++;
		end
	endfunction

	function int pending();
		return pending_words.size();
	endfunction
endclass

module tb_motor_command_frame_encoder_top;
	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] left_speed;
	logic [7:0] right_speed;
	logic       left_forward;
	logic       right_forward;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] frame_byte;
	logic       last_byte;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	frame_scoreboard sb = new();

	motor_command_frame_encoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_speed   (left_speed),
		.right_speed  (right_speed),
		.left_forward (left_forward),
		.right_forward(right_forward),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		left_speed = 8'h00;
		right_speed = 8'h00;
		left_forward = 1'b0;
		right_forward = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: a long hold-off takes priority over random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			hold_cycles--;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_word(frame_byte, last_byte);
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_command(input logic [7:0] ls, input logic [7:0] rs,
			input logic lf, input logic rf);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			left_speed = 8'($urandom_range(255));
			right_speed = 8'($urandom_range(255));
			left_forward = 1'($urandom_range(1));
			right_forward = 1'($urandom_range(1));
			@(negedge clk);
		end
		in_valid = 1'b1;
		left_speed = ls;
		right_speed = rs;
		left_forward = lf;
		right_forward = rf;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_command(ls, rs, lf, rf);
		@(negedge clk);
	endtask

	task automatic run_random(input int count);
		logic [7:0] ls;
		logic [7:0] rs;
		for (int i = 0; i < count; i++) begin
			ls = 8'($urandom_range(255));
			rs = 8'($urandom_range(255));
			// bias a few words toward the speed extremes
			if ($urandom_range(9) == 0) begin
				ls = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			if ($urandom_range(9) == 0) begin
				rs = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			send_command(ls, rs, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, alternating bit patterns, every direction combination
		send_command(8'h00, 8'h00, 1'b0, 1'b0);
		send_command(8'hFF, 8'hFF, 1'b1, 1'b1);
		send_command(8'hAA, 8'h55, 1'b1, 1'b0);
		send_command(8'h55, 8'hAA, 1'b0, 1'b1);
		send_command(8'h01, 8'h80, 1'b0, 1'b0);
		send_command(8'h80, 8'h01, 1'b1, 1'b1);
		send_command(8'hFF, 8'h00, 1'b0, 1'b1);
		send_command(8'h00, 8'hFF, 1'b1, 1'b0);
		send_command(8'h7F, 8'hFE, 1'b1, 1'b1);

		run_random(36);

		sender_idle_pct = 85;
		run_random(36);

		sender_idle_pct = 0;
		recv_stall_pct = 85;
		run_random(36);

		sender_idle_pct = 12;
		recv_stall_pct = 12;
		run_random(36);

		// hold off the receiver while commands keep coming, so the queue fills
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_cycles = 150;
		@(negedge clk);
		run_random(10);
		in_valid = 1'b0;

		while (sb.pending() > 0) begin
			@(negedge clk);
		end
		repeat (30) @(negedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("motor_command_frame_encoder_top regression: pass");
		end else begin
			$display("motor_command_frame_encoder_top regression: fail");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("motor_command_frame_encoder_top regression: fail");
		$finish;
	end
endmodule

// File: motor_command_frame_encoder_top.f
design/mcfe_pkg.sv
design/mcfe_front.sv
design/mcfe_fifo.sv
design/mcfe_back.sv
design/motor_command_frame_encoder_top.sv
sim/tb_motor_command_frame_encoder_top.sv
